// File: rtl/tdpt_pkg.sv
// Shared widths, constants and controller/datapath interface types for the prime tester.
package tdpt_pkg;

  // Width of the candidate port and of the internal datapath
  localparam int CAND_W     = 32;
  localparam int VALUE_BITS = 32;
  // Square of the trial divisor needs one bit of headroom over the value
  localparam int SQ_W       = VALUE_BITS + 1;
  // Step counter for the bit-serial remainder
  localparam int CNT_W      = (VALUE_BITS > 2) ? $clog2(VALUE_BITS) : 1;

  // Fixed numbers of the test
  localparam logic [VALUE_BITS-1:0] SMALLEST_PRIME = VALUE_BITS'(2);
  localparam logic [VALUE_BITS-1:0] FIRST_DIVISOR  = VALUE_BITS'(3);
  localparam logic [SQ_W-1:0]       FIRST_SQUARE   = SQ_W'(9);
  localparam logic [VALUE_BITS-1:0] DIVISOR_STEP   = VALUE_BITS'(2);
  localparam logic [CNT_W-1:0]      LAST_STEP      = CNT_W'(VALUE_BITS - 1);

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLASSIFY,
    ST_BOUND,
    ST_DIVIDE,
    ST_TEST
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;       // capture the candidate
    logic first_div;  // divisor := 3, square := 9
    logic div_init;   // clear remainder, load dividend shifter
    logic div_step;   // one restoring remainder step
    logic next_div;   // divisor += 2, square updated
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic below_two;
    logic is_two;
    logic even;
    logic sq_over;    // divisor squared exceeds the value
    logic div_last;   // current step is the last remainder step
    logic rem_zero;
  } dp_stat_t;

endpackage

// File: rtl/tdpt_datapath.sv
// Datapath: candidate register, trial divisor, running square and bit-serial remainder unit.
module tdpt_datapath (
  input  logic                      clk,
  input  logic [tdpt_pkg::CAND_W-1:0] candidate,
  input  tdpt_pkg::dp_cmd_t         cmd,
  output tdpt_pkg::dp_stat_t        stat
);
  import tdpt_pkg::*;

  logic [VALUE_BITS-1:0] value;
  logic [VALUE_BITS-1:0] divisor;
  logic [SQ_W-1:0]       square;
  logic [VALUE_BITS-1:0] rem;
  logic [VALUE_BITS-1:0] shifter;
  logic [CNT_W-1:0]      cnt;

  logic [VALUE_BITS:0]   trial;
  logic                  trial_fits;
  logic [VALUE_BITS+2:0] square_sum;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  assign trial      = {rem, shifter[VALUE_BITS-1]};
  assign trial_fits = trial >= {1'b0, divisor};

  // (d+2)^2 = d^2 + 4d + 4; stays below 2^(VALUE_BITS+1) while the bound is tested
  assign square_sum = (VALUE_BITS+3)'(square) + {1'b0, divisor, 2'b00} + (VALUE_BITS+3)'(4);

  // Candidate register, cut or extended to the datapath width
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value <= VALUE_BITS'(candidate);
    end
  end

  // Trial divisor and its square
  always_ff @(posedge clk) begin
    if (cmd.first_div) begin
      divisor <= FIRST_DIVISOR;
      square  <= FIRST_SQUARE;
    end else if (cmd.next_div) begin
      divisor <= divisor + DIVISOR_STEP;
      square  <= SQ_W'(square_sum);
    end
  end

  // Remainder unit, one dividend bit per cycle
  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem     <= '0;
      shifter <= value;
      cnt     <= '0;
    end else if (cmd.div_step) begin
      rem     <= trial_fits ? VALUE_BITS'(trial - {1'b0, divisor}) : VALUE_BITS'(trial);
      shifter <= {shifter[VALUE_BITS-2:0], 1'b0};
      cnt     <= cnt + CNT_W'(1);
    end
  end

  // Status back to the controller
  always_comb begin
    stat.below_two = value < SMALLEST_PRIME;
    stat.is_two    = value == SMALLEST_PRIME;
    stat.even      = ~value[0];
    stat.sq_over   = square > {1'b0, value};
    stat.div_last  = cnt == LAST_STEP;
    stat.rem_zero  = rem == '0;
  end

endmodule

// File: rtl/tdpt_ctrl.sv
// Controller: sequences classification, bound check and remainder runs, and drives the result.
module tdpt_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  tdpt_pkg::dp_stat_t stat,
  output tdpt_pkg::dp_cmd_t  cmd,
  output logic               busy,
  output logic               done,
  output logic               is_prime
);
  import tdpt_pkg::*;

  state_t state, state_next;
  logic   done_next;
  logic   prime_next;

  // State and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      done     <= 1'b0;
      is_prime <= 1'b0;
    end else begin
      state    <= state_next;
      done     <= done_next;
      is_prime <= prime_next;
    end
  end

  assign busy = state != ST_IDLE;

  // Next state and datapath commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    done_next  = 1'b0;
    prime_next = is_prime;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_CLASSIFY;
        end
      end
      ST_CLASSIFY: begin
        // zero, one and even numbers other than two are settled at once
        if (stat.below_two || (stat.even && !stat.is_two)) begin
          done_next  = 1'b1;
          prime_next = 1'b0;
          state_next = ST_IDLE;
        end else if (stat.is_two) begin
          done_next  = 1'b1;
          prime_next = 1'b1;
          state_next = ST_IDLE;
        end else begin
          cmd.first_div = 1'b1;
          state_next    = ST_BOUND;
        end
      end
      ST_BOUND: begin
        // no divisor left below the square root: prime
        if (stat.sq_over) begin
          done_next  = 1'b1;
          prime_next = 1'b1;
          state_next = ST_IDLE;
        end else begin
          cmd.div_init = 1'b1;
          state_next   = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = ST_TEST;
        end
      end
      ST_TEST: begin
        if (stat.rem_zero) begin
          done_next  = 1'b1;
          prime_next = 1'b0;
          state_next = ST_IDLE;
        end else begin
          cmd.next_div = 1'b1;
          state_next   = ST_BOUND;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/trial_division_prime_test.sv
// Top level of the trial-division prime tester.
//
// Usage: present a candidate and raise start while busy is low; the beat is
// taken at that clock edge and busy rises on the next cycle. The answer
// appears on is_prime, marked by done for exactly one cycle; the receiver
// must take it then, as there is no way to hold it off. busy is low again in
// the cycle that done is high, so the next start may come in that cycle.
// Zero, one, two and even candidates are settled in the classify state,
// without a trial divisor. An odd candidate is tried against the odd
// divisors 3, 5, ... up to its square root or the first one that divides it;
// none is tried for 3, 5 and 7. Each trial is a bit-serial remainder plus a
// bound check and a remainder test, so the remainder unit sets the rate.
// One candidate is worked at a time.
// Reset (rst, synchronous) returns the controller to idle and drops done;
// a test in flight is abandoned without a result.
module trial_division_prime_test (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [tdpt_pkg::CAND_W-1:0] candidate,
  output logic                        busy,
  output logic                        done,
  output logic                        is_prime
);
  import tdpt_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencer
  tdpt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .stat     (stat),
    .cmd      (cmd),
    .busy     (busy),
    .done     (done),
    .is_prime (is_prime)
  );

  // Arithmetic
  tdpt_datapath u_datapath (
    .clk       (clk),
    .candidate (candidate),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

// File: rtl/tdpt_checker.sv
// Port-level checker for the prime tester, bound to the top level.
module tdpt_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input logic is_prime
);

  // A result beat only shows while the block is idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("done while busy");

  // An accepted start makes the block busy
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("start beat not taken up");

  // The result strobe is a single cycle
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held longer than one cycle");

  // Finishing work always delivers a result
  a_finish_done: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $fell(busy) |-> done)
    else $error("busy dropped without a result");

  // A result beat carries a known answer
  a_known: assert property (@(posedge clk) disable iff (rst)
    done |-> !$isunknown(is_prime))
    else $error("result unknown");

endmodule

bind trial_division_prime_test tdpt_checker u_tdpt_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .is_prime  (is_prime)
);

// File: tb/tb.sv
// Self-checking testbench for the trial-division prime tester.
`timescale 1ns / 100ps

module tb;
  import tdpt_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int RAND_N       = 80;
  localparam int STALL_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 50;
  localparam int MAX_REPORTS  = 10;

  // Directed table columns: answer typed in, or left to the predictor
  localparam logic TYPED = 1'b1;
  localparam logic CALC  = 1'b0;

  typedef struct packed {
    logic [CAND_W-1:0] cand;
    logic              typed;
    logic              answer;
  } dir_row_t;

  typedef struct {
    logic [CAND_W-1:0] cand;
    logic              verdict;
  } verdict_t;

  localparam int DIR_N = 22;
  localparam logic [CAND_W+1:0] DIR_TABLE [0:DIR_N-1] = '{
    {32'd0,          TYPED, 1'b0},  // below two
    {32'd1,          TYPED, 1'b0},  // below two
    {32'd2,          TYPED, 1'b1},  // the one even prime
    {32'd3,          TYPED, 1'b1},  // first odd prime, no divisor tried
    {32'd4,          TYPED, 1'b0},
    {32'd9,          CALC,  1'b0},  // divisor squared equals candidate
    {32'd25,         CALC,  1'b0},
    {32'd7,          CALC,  1'b0},
    {32'd15,         CALC,  1'b0},
    {32'd49,         CALC,  1'b0},
    {32'd97,         CALC,  1'b0},
    {32'd63001,      CALC,  1'b0},  // 251 squared
    {32'd65521,      CALC,  1'b0},
    {32'd65537,      CALC,  1'b0},
    {32'd1000003,    CALC,  1'b0},
    {32'd16777213,   CALC,  1'b0},  // large odd, long trial run
    {32'hFFFF_FFFF,  CALC,  1'b0},  // all ones
    {32'hFFFF_FFFE,  TYPED, 1'b0},  // largest even
    {32'h8000_0000,  TYPED, 1'b0},
    {32'hAAAA_AAAA,  TYPED, 1'b0},
    {32'h5555_5555,  CALC,  1'b0},
    {32'd2,          TYPED, 1'b1}   // two again, with a short answer
  };

  logic              clk;
  logic              rst;
  logic              start;
  logic [CAND_W-1:0] candidate;
  logic              busy;
  logic              done;
  logic              is_prime;

  verdict_t verdict_q [$];
  int       err_count;
  int       stall_count;
  int       burst_left;

  trial_division_prime_test DUT (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .candidate (candidate),
    .busy      (busy),
    .done      (done),
    .is_prime  (is_prime)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Predictor: odd divisors from 3 while d <= n / d
  function automatic logic trial_div_verdict(input logic [CAND_W-1:0] c);
    longint unsigned n;
    longint unsigned d;
    n = c;
    n = n & ((64'd1 << VALUE_BITS) - 64'd1);
    if (n < 2) return 1'b0;
    if (n == 2) return 1'b1;
    if ((n & 64'd1) == 0) return 1'b0;
    d = 3;
    while (d <= n / d) begin
      if (n % d == 0) return 1'b0;
      d += 2;
    end
    return 1'b1;
  endfunction

  // Sender gap: mostly short, a few long, with runs of back-to-back beats
  function automatic int pick_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 8) begin
      burst_left = $urandom_range(5, 15);
      return 0;
    end
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Random candidates: small ones dominate, large ones kept cheap to test
  function automatic logic [CAND_W-1:0] random_candidate();
    int          r;
    int unsigned f;
    int unsigned q;
    r = $urandom_range(0, 99);
    if (r < 40) return $urandom_range(0, 4095);
    if (r < 65) return $urandom_range(0, 65535);
    if (r < 70) return $urandom_range(0, 1048575);
    if (r < 85) return $urandom() & ~32'd1;
    // odd multiple of a small odd factor, product kept within 32 bits
    f = 2 * $urandom_range(1, 49) + 1;
    q = $urandom_range(0, (32'hFFFF_FFFF / f) - 1) | 32'd1;
    return f * q;
  endfunction

  // Present one beat and hold it until the block takes it
  task automatic send_item(input logic [CAND_W-1:0] c, input logic verdict);
    int       gap;
    verdict_t v;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start     <= 1'b1;
    candidate <= c;
    do @(posedge clk); while (busy);
    v.cand    = c;
    v.verdict = verdict;
    verdict_q.push_back(v);
  endtask

  // Hold off until every pending answer is back
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (verdict_q.size() != 0);
  endtask

  // Result checker
  always @(posedge clk) begin
    verdict_t v;
    if (!rst && done) begin
      if (verdict_q.size() == 0) begin
        if (err_count < MAX_REPORTS)
          $display("%0t: unexpected result is_prime=%0b, nothing pending", $time, is_prime);
        err_count++;
      end else begin
        v = verdict_q.pop_front();
        if (is_prime !== v.verdict) begin
          if (err_count < MAX_REPORTS)
            $display("%0t: candidate %0d: expected is_prime=%0b, got %0b",
                     $time, v.cand, v.verdict, is_prime);
          err_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no beat in either direction
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) begin
      stall_count <= 0;
    end else if (stall_count >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

  // Stimulus
  initial begin
    dir_row_t          row;
    logic [CAND_W-1:0] c;
    err_count   = 0;
    stall_count = 0;
    burst_left  = 0;
    rst       <= 1'b1;
    start     <= 1'b0;
    candidate <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed rows
    for (int i = 0; i < DIR_N; i++) begin
      row = DIR_TABLE[i];
      send_item(row.cand, row.typed ? row.answer : trial_div_verdict(row.cand));
    end

    // random rows, with a full drain midway and now and then
    for (int i = 0; i < RAND_N; i++) begin
      if (i == RAND_N / 2 || $urandom_range(0, 19) == 0) wait_drained();
      c = random_candidate();
      send_item(c, trial_div_verdict(c));
    end
    start <= 1'b0;

    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
